[src/plac_pkg.sv]
// Shared types and constants for the point light accumulator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package plac_pkg;
  localparam int POS_W   = 24;
  localparam int RANGE_W = 16;
  localparam int COL_W   = 12;
  localparam int OUT_W   = 16;
  localparam int SLOT_W  = 6;
  localparam int IDX_W   = 2;
  localparam int MAG_W   = POS_W + 1;
  localparam int SQ_W    = 2 * MAG_W - 1;
  localparam int D2_W    = SQ_W + 1;
  localparam int DEN_W   = D2_W + 3;
  localparam int NUM_W   = 2 * RANGE_W + 16;
  localparam int W_W     = 17;
  localparam int PROD_W  = COL_W + W_W;
  localparam int TERM_W  = PROD_W - 16;

  localparam logic [IDX_W-1:0] REG_AMB_RED   = 2'd0;
  localparam logic [IDX_W-1:0] REG_AMB_GREEN = 2'd1;
  localparam logic [IDX_W-1:0] REG_AMB_BLUE  = 2'd2;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SHADE = 1'b1;

  typedef enum logic [1:0] {CH_RED = 2'd0, CH_GREEN = 2'd1, CH_BLUE = 2'd2} chan_t;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_W-1:0]       slot;
    logic                    enable;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RANGE_W-1:0]      light_range;
    logic [COL_W-1:0]        light_red;
    logic [COL_W-1:0]        light_green;
    logic [COL_W-1:0]        light_blue;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             clipped;
  } out_item_t;

  typedef struct packed {
    logic  wr_light;
    logic  start_q;
    logic  rd;
    logic  sqx;
    logic  sqy;
    logic  sum;
    logic  den;
    logic  div_start;
    logic  mul_en;
    chan_t mul_ch;
    logic  cnt_inc;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic en_l;
    logic last;
    logic div_done;
  } status_t;
endpackage

[src/plac_ifs.sv]
// Channel interfaces: input items, result items and register writes.
// Depends on plac_pkg.
`timescale 1ns / 1ps
interface plac_in_if import plac_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [SLOT_W-1:0]       slot;
  logic                    enable;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [RANGE_W-1:0]      light_range;
  logic [COL_W-1:0]        light_red;
  logic [COL_W-1:0]        light_green;
  logic [COL_W-1:0]        light_blue;
  modport source (output valid, kind, slot, enable, pos_x, pos_y, light_range,
                  light_red, light_green, light_blue, input ready);
  modport sink (input valid, kind, slot, enable, pos_x, pos_y, light_range,
                light_red, light_green, light_blue, output ready);
endinterface

interface plac_out_if import plac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;
  logic             clipped;
  modport source (output valid, red_out, green_out, blue_out, clipped, input ready);
  modport sink (input valid, red_out, green_out, blue_out, clipped, output ready);
endinterface

interface plac_cfg_if import plac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [COL_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/plac_div.sv]
// Restoring divider for the light weight: min(65536, floor(num / den)).
// One quotient bit per cycle. Depends on plac_pkg.
`timescale 1ns / 1ps
module plac_div import plac_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [W_W-1:0]   w
);
  localparam int SH_W = DEN_W + 16;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]  dsh_r, dsh_nxt;
  logic [W_W-1:0]   q_r, q_nxt;
  logic             ge;

  assign ge = {{(SH_W-NUM_W){1'b0}}, rem_r} >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 5'd0;
      rem_nxt  = num;
      dsh_nxt  = {den, 16'd0};
      q_nxt    = '0;
    end else if (busy_r) begin
      if (step_r == 5'd0 && ge) begin
        // quotient at least 65536: clamp to full weight
        q_nxt    = W_W'(17'h10000);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (step_r != 5'd0) begin
          q_nxt = {q_r[W_W-2:0], ge};
          if (ge) rem_nxt = rem_r - dsh_r[NUM_W-1:0];
        end
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd16) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign w    = q_r;
endmodule

[src/plac_dp.sv]
// Datapath: light tables, ambient registers, distance, weight and sums.
// Depends on plac_pkg and plac_div.
`timescale 1ns / 1ps
module plac_dp import plac_pkg::*; #(
  parameter int NUM_LIGHTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          status,
  input  in_item_t         item,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [COL_W-1:0] cfg_data,
  output out_item_t        result
);
  localparam int AW    = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;
  localparam int SW    = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int SUM_W = COL_W + $clog2(NUM_LIGHTS + 1);
  localparam int SET_W = RANGE_W + 3 * COL_W;

  logic [2*POS_W-1:0] pos_mem [NUM_LIGHTS];
  logic [SET_W-1:0]   set_mem [NUM_LIGHTS];
  logic [NUM_LIGHTS-1:0] en_r;

  logic [COL_W-1:0] amb_r [3];
  logic [AW-1:0]    cnt_r;
  logic             en_l_r;
  logic [2*POS_W-1:0] pos_rd_r;
  logic [SET_W-1:0]   set_rd_r;
  logic signed [POS_W-1:0] qx_r, qy_r;
  logic [SQ_W-1:0]  dxsq_r, dysq_r;
  logic [2*RANGE_W-1:0] rsq_r;
  logic [D2_W-1:0]  d2_r;
  logic [DEN_W-1:0] den_r;
  logic [SUM_W-1:0] sum_r [3];
  out_item_t        res_r;

  logic [SW-1:0]    slot_ext;
  logic [AW-1:0]    waddr;
  logic             slot_ok;
  logic signed [POS_W-1:0] lx, ly, qsel, lsel;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0] mag;
  logic [SQ_W-1:0]  sq;
  logic             div_done;
  logic [W_W-1:0]   w;
  logic [COL_W-1:0] col;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0] sat_lim;

  assign slot_ext = SW'(item.slot);
  assign waddr    = slot_ext[AW-1:0];
  assign slot_ok  = {{(32-SW){1'b0}}, slot_ext} < NUM_LIGHTS;

  always_ff @(posedge clk) begin
    if (cmd.wr_light && slot_ok) begin
      pos_mem[waddr] <= {item.pos_x, item.pos_y};
      set_mem[waddr] <= {item.light_range, item.light_red, item.light_green,
                         item.light_blue};
    end
    if (cmd.rd) begin
      pos_rd_r <= pos_mem[cnt_r];
      set_rd_r <= set_mem[cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= '0;
      amb_r[0] <= '0;
      amb_r[1] <= '0;
      amb_r[2] <= '0;
    end else begin
      if (cmd.wr_light && slot_ok) en_r[waddr] <= item.enable;
      if (cfg_we) begin
        case (cfg_idx)
          REG_AMB_RED:   amb_r[0] <= cfg_data;
          REG_AMB_GREEN: amb_r[1] <= cfg_data;
          REG_AMB_BLUE:  amb_r[2] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign lx   = pos_rd_r[2*POS_W-1:POS_W];
  assign ly   = pos_rd_r[POS_W-1:0];
  assign qsel = cmd.sqy ? qy_r : qx_r;
  assign lsel = cmd.sqy ? ly : lx;
  assign diff = {qsel[POS_W-1], qsel} - {lsel[POS_W-1], lsel};
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign sq   = SQ_W'(mag) * SQ_W'(mag);

  always_comb begin
    case (cmd.mul_ch)
      CH_RED:   col = set_rd_r[3*COL_W-1:2*COL_W];
      CH_GREEN: col = set_rd_r[2*COL_W-1:COL_W];
      CH_BLUE:  col = set_rd_r[COL_W-1:0];
      default:  col = '0;
    endcase
  end
  assign prod    = PROD_W'(col) * PROD_W'(w);
  assign sat_lim = SUM_W'({OUT_W{1'b1}});

  plac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   ({rsq_r, 16'd0}),
    .den   (den_r),
    .done  (div_done),
    .w     (w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start_q) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_q) begin
      qx_r     <= item.pos_x;
      qy_r     <= item.pos_y;
      sum_r[0] <= SUM_W'(amb_r[0]);
      sum_r[1] <= SUM_W'(amb_r[1]);
      sum_r[2] <= SUM_W'(amb_r[2]);
    end
    if (cmd.rd) en_l_r <= en_r[cnt_r];
    if (cmd.sqx) begin
      dxsq_r <= sq;
      rsq_r  <= (2*RANGE_W)'(set_rd_r[SET_W-1:3*COL_W]) *
                (2*RANGE_W)'(set_rd_r[SET_W-1:3*COL_W]);
    end
    if (cmd.sqy) dysq_r <= sq;
    if (cmd.sum) d2_r <= D2_W'(dxsq_r) + D2_W'(dysq_r);
    if (cmd.den) den_r <= {d2_r, 3'b000} + {2'b00, d2_r, 1'b0};
    if (cmd.mul_en) begin
      sum_r[cmd.mul_ch] <= sum_r[cmd.mul_ch] + SUM_W'(prod[PROD_W-1:16]);
    end
    if (cmd.load_out) begin
      res_r.red_out   <= (sum_r[0] > sat_lim) ? {OUT_W{1'b1}} : OUT_W'(sum_r[0]);
      res_r.green_out <= (sum_r[1] > sat_lim) ? {OUT_W{1'b1}} : OUT_W'(sum_r[1]);
      res_r.blue_out  <= (sum_r[2] > sat_lim) ? {OUT_W{1'b1}} : OUT_W'(sum_r[2]);
      res_r.clipped   <= (sum_r[0] > sat_lim) || (sum_r[1] > sat_lim) ||
                         (sum_r[2] > sat_lim);
    end
  end

  assign status.en_l     = en_l_r;
  assign status.last     = cnt_r == AW'(NUM_LIGHTS - 1);
  assign status.div_done = div_done;
  assign result          = res_r;
endmodule

[src/plac_ctrl.sv]
// Controller: accepts items, sequences the per-light walk, owns output valid.
// Depends on plac_pkg.
`timescale 1ns / 1ps
module plac_ctrl import plac_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);
  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RD   = 13'b0000000000010,
    S_SQX  = 13'b0000000000100,
    S_SQY  = 13'b0000000001000,
    S_SUM  = 13'b0000000010000,
    S_DEN  = 13'b0000000100000,
    S_DVS  = 13'b0000001000000,
    S_DIV  = 13'b0000010000000,
    S_MR   = 13'b0000100000000,
    S_MG   = 13'b0001000000000,
    S_MB   = 13'b0010000000000,
    S_NEXT = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;

  assign in_ready = state_r == S_IDLE;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_ch = CH_RED;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_kind == KIND_SHADE) begin
            cmd.start_q = 1'b1;
            state_nxt   = S_RD;
          end else begin
            cmd.wr_light = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.sqx   = 1'b1;
        state_nxt = status.en_l ? S_SQY : S_NEXT;
      end
      S_SQY: begin
        cmd.sqy   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        cmd.den   = 1'b1;
        state_nxt = S_DVS;
      end
      S_DVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_MR;
      end
      S_MR: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ch = CH_RED;
        state_nxt  = S_MG;
      end
      S_MG: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ch = CH_GREEN;
        state_nxt  = S_MB;
      end
      S_MB: begin
        cmd.mul_en = 1'b1;
        cmd.mul_ch = CH_BLUE;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (status.last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_FIN: begin
        // hold the sums until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken item");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");
  a_div_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && status.div_done) |=> state_r == S_MR)
    else $error("weight ready but accumulation skipped");
`endif
endmodule

[src/point_light_accumulator_unit.sv]
// Point light accumulator top level: channel wiring, controller, datapath.
// Depends on plac_pkg, plac_ifs, plac_ctrl and plac_dp.
//
// Usage: in_ch carries items. Kind 0 writes one light slot and is taken
// with no result; slots at or beyond NUM_LIGHTS are dropped.
// Kind 1 shades a point and yields one item on out_ch. cfg_ch writes the
// ambient color registers and is always ready.
// A shade item walks every slot once. A disabled slot is read and then
// skipped; an enabled slot also takes the square, sum, scale, weight
// divide (the one-bit-per-cycle weight divider) and three color multiply
// steps. A weight that clamps at full ends the divide early. The result
// is valid when the sums load into the output register after the walk;
// in_ready rises as the result loads.
// Reset clears all enable bits (every light off) and the ambient levels;
// no clearing pass is needed. While out_ch stalls the result holds in its
// output register; write items are still taken, and a second shade item
// waits at the end of its walk until the register frees.
`timescale 1ns / 1ps
module point_light_accumulator_unit import plac_pkg::*; #(
  parameter int NUM_LIGHTS = 64
) (
  input logic         clk,
  input logic         rst_n,
  plac_in_if.sink     in_ch,
  plac_out_if.source  out_ch,
  plac_cfg_if.sink    cfg_ch
);
  cmd_t      cmd;
  status_t   status;
  in_item_t  item;
  out_item_t result;

  assign item.kind        = in_ch.kind;
  assign item.slot        = in_ch.slot;
  assign item.enable      = in_ch.enable;
  assign item.pos_x       = in_ch.pos_x;
  assign item.pos_y       = in_ch.pos_y;
  assign item.light_range = in_ch.light_range;
  assign item.light_red   = in_ch.light_red;
  assign item.light_green = in_ch.light_green;
  assign item.light_blue  = in_ch.light_blue;

  assign cfg_ch.ready     = 1'b1;
  assign out_ch.red_out   = result.red_out;
  assign out_ch.green_out = result.green_out;
  assign out_ch.blue_out  = result.blue_out;
  assign out_ch.clipped   = result.clipped;

  plac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  plac_dp #(.NUM_LIGHTS(NUM_LIGHTS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .item     (item),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .result   (result)
  );
endmodule

[dv/tb_top.sv]
// Testbench for the point light accumulator: drives write and shade items,
// predicts each shaded color and checks it. Depends on plac_pkg, plac_ifs and point_light_accumulator_unit.
`timescale 1ns / 1ps
module tb_top;
  import plac_pkg::*;

  localparam int N_LIGHTS = 64;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int LONG_STALL = 600;

  logic clk;
  logic rst_n;
  int   cycles;
  int   errors;
  bit   calm;
  int   hold_off;
  bit   stall_req;
  bit   stall_taken;
  int   stall_left;

  plac_in_if  in_ch ();
  plac_out_if out_ch ();
  plac_cfg_if cfg_ch ();

  point_light_accumulator_unit #(.NUM_LIGHTS(N_LIGHTS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Shadow light table and ambient levels
  logic                    lamp_on [N_LIGHTS];
  logic signed [POS_W-1:0] lamp_x [N_LIGHTS];
  logic signed [POS_W-1:0] lamp_y [N_LIGHTS];
  logic [RANGE_W-1:0]      lamp_range [N_LIGHTS];
  logic [COL_W-1:0]        lamp_col [N_LIGHTS][3];
  logic [COL_W-1:0]        amb_level [3];
  out_item_t               shade_q [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic out_item_t shade_point(logic signed [POS_W-1:0] px,
                                            logic signed [POS_W-1:0] py);
    out_item_t  r;
    logic [63:0] acc [3];
    logic signed [MAG_W-1:0] dx, dy;
    logic [63:0] d2, num, w;
    acc[0] = 64'(amb_level[0]);
    acc[1] = 64'(amb_level[1]);
    acc[2] = 64'(amb_level[2]);
    for (int i = 0; i < N_LIGHTS; i++) begin
      if (!lamp_on[i]) continue;
      dx = MAG_W'(px) - MAG_W'(lamp_x[i]);
      dy = MAG_W'(py) - MAG_W'(lamp_y[i]);
      d2 = 64'($signed(64'(dx)) * $signed(64'(dx)))
         + 64'($signed(64'(dy)) * $signed(64'(dy)));
      if (d2 == 0) w = 65536;
      else begin
        num = (64'(lamp_range[i]) * 64'(lamp_range[i])) << 16;
        w = num / (d2 * 10);
        if (w > 65536) w = 65536;
      end
      for (int c = 0; c < 3; c++) acc[c] += (64'(lamp_col[i][c]) * w) >> 16;
    end
    r.clipped = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (acc[c] > 65535) begin
        acc[c] = 65535;
        r.clipped = 1'b1;
      end
    end
    r.red_out = acc[0][15:0];
    r.green_out = acc[1][15:0];
    r.blue_out = acc[2][15:0];
    return r;
  endfunction

  // drop valid only when a gap follows
  task automatic idle_burst();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_item(in_item_t it);
    idle_burst();
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.slot <= it.slot;
    in_ch.enable <= it.enable;
    in_ch.pos_x <= it.pos_x;
    in_ch.pos_y <= it.pos_y;
    in_ch.light_range <= it.light_range;
    in_ch.light_red <= it.light_red;
    in_ch.light_green <= it.light_green;
    in_ch.light_blue <= it.light_blue;
    do @(posedge clk); while (!in_ch.ready);
    // item accepted at this edge: update the shadow table or queue the prediction
    if (it.kind == KIND_WRITE) begin
      lamp_on[it.slot] = it.enable;
      lamp_x[it.slot] = it.pos_x;
      lamp_y[it.slot] = it.pos_y;
      lamp_range[it.slot] = it.light_range;
      lamp_col[it.slot][0] = it.light_red;
      lamp_col[it.slot][1] = it.light_green;
      lamp_col[it.slot][2] = it.light_blue;
    end else begin
      shade_q.push_back(shade_point(it.pos_x, it.pos_y));
    end
  endtask

  task automatic write_ambient(logic [IDX_W-1:0] idx, logic [COL_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    amb_level[idx] = val;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (4 * N_LIGHTS + 28 * N_LIGHTS + 20) @(posedge clk);
  endtask

  task automatic set_ambient(logic [COL_W-1:0] r, logic [COL_W-1:0] g,
                             logic [COL_W-1:0] b);
    drain();
    write_ambient(REG_AMB_RED, r);
    write_ambient(REG_AMB_GREEN, g);
    write_ambient(REG_AMB_BLUE, b);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_item_t rand_item();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  function automatic in_item_t light_item(int s, bit en, int x, int y, int rg,
                                          int r, int g, int b);
    in_item_t it;
    it.kind = KIND_WRITE;
    it.slot = SLOT_W'(s);
    it.enable = en;
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.light_range = RANGE_W'(rg);
    it.light_red = COL_W'(r);
    it.light_green = COL_W'(g);
    it.light_blue = COL_W'(b);
    return it;
  endfunction

  function automatic in_item_t query_item(int x, int y);
    in_item_t it;
    it = rand_item();
    it.kind = KIND_SHADE;
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    return it;
  endfunction

  function automatic int rand_pos(bit wide);
    if (wide) return int'($signed(24'($urandom)));
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // Long receiver stall, counted here once requested
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      stall_taken <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      stall_left <= LONG_STALL;
      stall_taken <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result checker with random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_off <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (shade_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          out_item_t e;
          e = shade_q.pop_front();
          if (out_ch.red_out !== e.red_out) begin
            $error("red_out exp %0d got %0d", e.red_out, out_ch.red_out); errors++;
          end
          if (out_ch.green_out !== e.green_out) begin
            $error("green_out exp %0d got %0d", e.green_out, out_ch.green_out); errors++;
          end
          if (out_ch.blue_out !== e.blue_out) begin
            $error("blue_out exp %0d got %0d", e.blue_out, out_ch.blue_out); errors++;
          end
          if (out_ch.clipped !== e.clipped) begin
            $error("clipped exp %0d got %0d", e.clipped, out_ch.clipped); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        hold_off <= $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_item(query_item(0, 0));
    // zero distance with zero range still gives full weight
    send_item(light_item(0, 1, 100, -100, 0, 4095, 0, 2048));
    send_item(query_item(100, -100));
    // zero range at nonzero distance
    send_item(query_item(101, -100));
    send_item(light_item(63, 1, 8388607, -8388608, 65535, 4095, 4095, 4095));
    send_item(query_item(-8388608, 8388607));
    send_item(query_item(8388607, -8388608));
    send_item(query_item(8388000, -8388000));
    for (int s = 1; s < 20; s++)
      send_item(light_item(s, 1, 0, 0, 65535, 4095, 4095, 4095));
    send_item(query_item(5, 5));
    for (int s = 0; s < 20; s++) send_item(light_item(s, 0, 0, 0, 0, 0, 0, 0));
    send_item(query_item(0, 0));
  endtask

  task automatic test_ambient();
    set_ambient(12'hFFF, 12'hFFF, 12'hFFF);
    send_item(query_item(0, 0));
    set_ambient(12'h123, 12'h000, 12'hABC);
    send_item(query_item(1, 1));
  endtask

  task automatic test_backpressure();
    drain();
    stall_req = 1'b1;
    for (int k = 0; k < 6; k++) begin
      send_item(light_item($urandom_range(0, 63), 1, rand_pos(0), rand_pos(0),
                           $urandom_range(0, 65535), $urandom_range(0, 4095),
                           $urandom_range(0, 4095), $urandom_range(0, 4095)));
      send_item(query_item(rand_pos(0), rand_pos(0)));
    end
  endtask

  task automatic test_random(int n_items);
    in_item_t it;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items * 3 / 4) calm = 1'b1;
      if (k % 500 == 250)
        set_ambient(COL_W'($urandom_range(0, 4095)), COL_W'($urandom_range(0, 4095)),
                    COL_W'($urandom_range(0, 4095)));
      if ($urandom_range(0, 2) != 0) begin
        it = rand_item();
        it.kind = KIND_WRITE;
        // keep most lights clustered near queries; disable often to keep walks short
        if ($urandom_range(0, 3) != 0) begin
          it.pos_x = POS_W'(rand_pos(0));
          it.pos_y = POS_W'(rand_pos(0));
        end
        if ($urandom_range(0, 1) == 0) it.slot = SLOT_W'($urandom_range(0, 7));
        it.enable = ($urandom_range(0, 2) == 0);
        send_item(it);
      end else begin
        send_item(query_item(rand_pos($urandom_range(0, 4) == 0),
                             rand_pos($urandom_range(0, 4) == 0)));
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    calm = 1'b0;
    stall_req = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.slot = '0;
    in_ch.enable = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.light_range = '0;
    in_ch.light_red = '0;
    in_ch.light_green = '0;
    in_ch.light_blue = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_AMB_RED;
    cfg_ch.data = '0;
    for (int i = 0; i < N_LIGHTS; i++) begin
      lamp_on[i] = 1'b0;
      lamp_x[i] = '0;
      lamp_y[i] = '0;
      lamp_range[i] = '0;
      for (int c = 0; c < 3; c++) lamp_col[i][c] = '0;
    end
    for (int c = 0; c < 3; c++) amb_level[c] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_ambient();
    test_backpressure();
    set_ambient(0, 0, 0);
    test_random(2000);
    drain();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
